FILE: hw/rtl/r2q_pkg.sv
// ----------------------------------------------------------------------------
// r2q_pkg
// Shared widths, defaults and component codes for the rotation matrix to
// quaternion converter.
// ----------------------------------------------------------------------------
package r2q_pkg;

  // Width of every matrix element and quaternion component on the channels.
  localparam int DATA_W = 16;

  // Default number of fraction bits (one is 2^FRAC_BITS).
  localparam int FRAC_BITS_DEF = 14;

  // Pre-scale applied to each candidate sum before its square root.
  localparam int ROOT_SHIFT = 31;

  // Quaternion component codes, in the order used for tie breaking.
  typedef enum logic [1:0] {
    COMP_W = 2'd0,
    COMP_X = 2'd1,
    COMP_Y = 2'd2,
    COMP_Z = 2'd3
  } comp_t;

endpackage

FILE: hw/rtl/r2q_mat_if.sv
// ----------------------------------------------------------------------------
// r2q_mat_if
// Valid/ready channel carrying the nine elements of one rotation matrix.
// ----------------------------------------------------------------------------
interface r2q_mat_if
  import r2q_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] m11, m12, m13;
  logic signed [DATA_W-1:0] m21, m22, m23;
  logic signed [DATA_W-1:0] m31, m32, m33;

  modport source (
    output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
    input  ready
  );

  modport sink (
    input  valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
    output ready
  );
endinterface

FILE: hw/rtl/r2q_quat_if.sv
// ----------------------------------------------------------------------------
// r2q_quat_if
// Valid/ready channel carrying one unit quaternion.
// ----------------------------------------------------------------------------
interface r2q_quat_if
  import r2q_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] quat_w, quat_x, quat_y, quat_z;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z,
    input  ready
  );

  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z,
    output ready
  );
endinterface

FILE: hw/rtl/r2q_isqrt.sv
// ----------------------------------------------------------------------------
// r2q_isqrt
// Pipelined integer square root, one result bit per stage, several lanes in
// step. Gives the root rounded down and the remainder (radicand - root^2).
// ----------------------------------------------------------------------------
module r2q_isqrt
  import r2q_pkg::*;
#(
  parameter int LANES = 4,
  parameter int IW    = 50,
  parameter int SW    = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [LANES-1:0][IW-1:0]         in_rad,
  input  logic [SW-1:0]                    in_side,
  output logic                             out_valid,
  output logic [LANES-1:0][IW/2-1:0]       out_root,
  output logic [LANES-1:0][IW/2:0]         out_rem,
  output logic [SW-1:0]                    out_side
);

  localparam int OW = IW / 2;
  localparam int RW = OW + 3;

  logic                        vld  [0:OW];
  logic [LANES-1:0][IW-1:0]    rad  [0:OW];
  logic [LANES-1:0][OW-1:0]    root [0:OW];
  logic [LANES-1:0][RW-1:0]    rem  [0:OW];
  logic [SW-1:0]               side [0:OW];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign side[0] = in_side;

  for (genvar s = 0; s < OW; s++) begin : g_stage
    logic [LANES-1:0][IW-1:0] rad_next;
    logic [LANES-1:0][OW-1:0] root_next;
    logic [LANES-1:0][RW-1:0] rem_next;

    always_comb begin
      logic [RW-1:0] rp;
      logic [RW-1:0] trial;
      for (int l = 0; l < LANES; l++) begin
        rp    = {rem[s][l][RW-3:0], rad[s][l][IW-1:IW-2]};
        trial = {1'b0, root[s][l], 2'b01};
        rad_next[l] = {rad[s][l][IW-3:0], 2'b00};
        if (rp >= trial) begin
          rem_next[l]  = rp - trial;
          root_next[l] = {root[s][l][OW-2:0], 1'b1};
        end else begin
          rem_next[l]  = rp;
          root_next[l] = {root[s][l][OW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[s+1]  <= rad_next;
        root[s+1] <= root_next;
        rem[s+1]  <= rem_next;
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[OW];
  assign out_root  = root[OW];
  assign out_side  = side[OW];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_rem[l] = rem[OW][l][OW:0];
    end
  end

endmodule

FILE: hw/rtl/r2q_div.sv
// ----------------------------------------------------------------------------
// r2q_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The quotient is known to fit in QW bits.
// ----------------------------------------------------------------------------
module r2q_div
  import r2q_pkg::*;
#(
  parameter int LANES = 4,
  parameter int DW    = 40,
  parameter int NW    = 26,
  parameter int QW    = 15,
  parameter int SW    = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][DW-1:0]   in_num,
  input  logic [NW-1:0]              in_den,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   out_quo,
  output logic [SW-1:0]              out_side
);

  logic                       vld  [0:QW];
  logic [LANES-1:0][NW-1:0]   rem  [0:QW];
  logic [LANES-1:0][QW-1:0]   low  [0:QW];
  logic [LANES-1:0][QW-1:0]   quo  [0:QW];
  logic [NW-1:0]              den  [0:QW];
  logic [SW-1:0]              side [0:QW];

  assign vld[0]  = in_valid;
  assign quo[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] = NW'(in_num[l][DW-1:QW]);
      low[0][l] = in_num[l][QW-1:0];
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [LANES-1:0][NW-1:0] rem_next;
    logic [LANES-1:0][QW-1:0] low_next;
    logic [LANES-1:0][QW-1:0] quo_next;

    always_comb begin
      logic [NW:0] rp;
      logic [NW:0] dd;
      dd = {1'b0, den[s]};
      for (int l = 0; l < LANES; l++) begin
        rp          = {rem[s][l], low[s][l][QW-1]};
        low_next[l] = {low[s][l][QW-2:0], 1'b0};
        if (rp >= dd) begin
          rem_next[l] = NW'(rp - dd);
          quo_next[l] = {quo[s][l][QW-2:0], 1'b1};
        end else begin
          rem_next[l] = rp[NW-1:0];
          quo_next[l] = {quo[s][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= rem_next;
        low[s+1]  <= low_next;
        quo[s+1]  <= quo_next;
        den[s+1]  <= den[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_side  = side[QW];

endmodule

FILE: hw/rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed fixed point to a unit quaternion.
// ----------------------------------------------------------------------------
// Usage. Matrices arrive as beats on the mat channel and quaternions leave as
// beats on the quat channel; both are valid/ready and a beat moves on a clock
// edge where valid and ready are both high. Each matrix yields exactly one
// quaternion, in order.
// Throughput is one beat per cycle while the receiver does not stall. The work
// is a single stalling pipeline: one input stage, the four candidate square
// roots (one root bit per stage), a norm sum stage, the norm square root (one
// bit per stage), a dividend stage, the four normalising divisions (one
// quotient bit per stage) and the output register.
// When the receiver stalls, the whole pipeline holds, and mat.ready drops in
// the same cycle, so no beat is lost or repeated. The output register is the
// last stage, so a new matrix is taken while a finished result waits as long
// as that result is taken in the same cycle.
// Synchronous reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
  import r2q_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  r2q_mat_if.sink     mat,
  r2q_quat_if.source  quat
);

  // Signed width of the raw candidate sums, then the clamped unsigned width.
  localparam int SSW = (FRAC_BITS + 3 > DATA_W + 3) ? FRAC_BITS + 3 : DATA_W + 3;
  localparam int SUW = SSW - 1;
  // Candidate radicand S << ROOT_SHIFT, rounded up to an even width.
  localparam int MRW = SUW + ROOT_SHIFT;
  localparam int MIW = MRW + (MRW % 2);
  localparam int MOW = MIW / 2;
  // Sum of four squared magnitudes and its root.
  localparam int NIW = MIW + 2;
  localparam int NOW = NIW / 2;
  // Dividend mag * one + n / 2 and quotient width (the quotient is at most one).
  localparam int DW  = MOW + FRAC_BITS + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int SRC_W = DATA_W + 1;

  localparam logic signed [SSW-1:0] ONE_S = SSW'(64'(1) << FRAC_BITS);
  localparam int ONE_I = 1 << FRAC_BITS;

  logic en;

  // The whole pipeline advances unless a finished result is held back.
  assign en        = !quat.valid || quat.ready;
  assign mat.ready = en;

  // --------------------------------------------------------------------------
  // Input stage: candidate sums, clamping, largest component and the signs.
  // --------------------------------------------------------------------------
  logic signed [SSW-1:0] s_raw [4];
  logic [3:0][SUW-1:0]   s_cl;
  logic [3:0]            neg;
  comp_t                 big;

  logic                  in_v;
  logic [3:0][SUW-1:0]   in_s;
  logic [3:0]            in_neg;

  always_comb begin
    logic signed [SSW-1:0] a, b, c;
    logic signed [SRC_W-1:0] d32_23, d13_31, d21_12, p21_12, p13_31, p32_23;
    a = SSW'(mat.m11);
    b = SSW'(mat.m22);
    c = SSW'(mat.m33);
    s_raw[0] = a + b + c + ONE_S;
    s_raw[1] = a - b - c + ONE_S;
    s_raw[2] = -a + b - c + ONE_S;
    s_raw[3] = -a - b + c + ONE_S;
    for (int i = 0; i < 4; i++) begin
      s_cl[i] = s_raw[i][SSW-1] ? '0 : s_raw[i][SUW-1:0];
    end

    // Strict compare keeps the earlier component on a tie.
    big = COMP_W;
    if (s_cl[1] > s_cl[big]) big = COMP_X;
    if (s_cl[2] > s_cl[big]) big = COMP_Y;
    if (s_cl[3] > s_cl[big]) big = COMP_Z;

    d32_23 = SRC_W'(mat.m32) - SRC_W'(mat.m23);
    d13_31 = SRC_W'(mat.m13) - SRC_W'(mat.m31);
    d21_12 = SRC_W'(mat.m21) - SRC_W'(mat.m12);
    p21_12 = SRC_W'(mat.m21) + SRC_W'(mat.m12);
    p13_31 = SRC_W'(mat.m13) + SRC_W'(mat.m31);
    p32_23 = SRC_W'(mat.m32) + SRC_W'(mat.m23);

    // The largest component always stays positive.
    neg = '0;
    case (big)
      COMP_W: begin
        neg[1] = d32_23[SRC_W-1];
        neg[2] = d13_31[SRC_W-1];
        neg[3] = d21_12[SRC_W-1];
      end
      COMP_X: begin
        neg[0] = d32_23[SRC_W-1];
        neg[2] = p21_12[SRC_W-1];
        neg[3] = p13_31[SRC_W-1];
      end
      COMP_Y: begin
        neg[0] = d13_31[SRC_W-1];
        neg[1] = p21_12[SRC_W-1];
        neg[3] = p32_23[SRC_W-1];
      end
      COMP_Z: begin
        neg[0] = d21_12[SRC_W-1];
        neg[1] = p13_31[SRC_W-1];
        neg[2] = p32_23[SRC_W-1];
      end
      default: neg = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (en) begin
      in_v <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_s   <= s_cl;
      in_neg <= neg;
    end
  end

  // --------------------------------------------------------------------------
  // Candidate magnitudes: mag = floor(sqrt(S << ROOT_SHIFT)) in four lanes.
  // The clamped sums ride along so that mag^2 can be rebuilt as radicand
  // minus remainder without a multiplier.
  // --------------------------------------------------------------------------
  logic [3:0][MIW-1:0]  mag_rad;
  logic                 mag_v;
  logic [3:0][MOW-1:0]  mag_root;
  logic [3:0][MOW:0]    mag_rem;
  logic [3:0][SUW-1:0]  mag_s;
  logic [3:0]           mag_neg;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_rad[i] = MIW'(in_s[i]) << ROOT_SHIFT;
    end
  end

  r2q_isqrt #(
    .LANES (4),
    .IW    (MIW),
    .SW    (4 * SUW + 4)
  ) u_mag_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_v),
    .in_rad    (mag_rad),
    .in_side   ({in_s, in_neg}),
    .out_valid (mag_v),
    .out_root  (mag_root),
    .out_rem   (mag_rem),
    .out_side  ({mag_s, mag_neg})
  );

  // --------------------------------------------------------------------------
  // Norm sum: sum of mag^2, each taken as (S << ROOT_SHIFT) - remainder.
  // --------------------------------------------------------------------------
  logic [NIW-1:0]       sq_sum;
  logic                 sq_v;
  logic [NIW-1:0]       sq_acc;
  logic [3:0][MOW-1:0]  sq_mag;
  logic [3:0]           sq_neg;

  always_comb begin
    sq_sum = '0;
    for (int i = 0; i < 4; i++) begin
      sq_sum = sq_sum + ((NIW'(mag_s[i]) << ROOT_SHIFT) - NIW'(mag_rem[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= 1'b0;
    end else if (en) begin
      sq_v <= mag_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_acc <= sq_sum;
      sq_mag <= mag_root;
      sq_neg <= mag_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Euclidean norm n = floor(sqrt(sum)); the magnitudes ride along.
  // --------------------------------------------------------------------------
  logic                 nrm_v;
  logic [0:0][NOW-1:0]  nrm_root;
  logic [0:0][NOW:0]    nrm_rem;
  logic [3:0][MOW-1:0]  nrm_mag;
  logic [3:0]           nrm_neg;

  r2q_isqrt #(
    .LANES (1),
    .IW    (NIW),
    .SW    (4 * MOW + 4)
  ) u_norm_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v),
    .in_rad    (sq_acc),
    .in_side   ({sq_mag, sq_neg}),
    .out_valid (nrm_v),
    .out_root  (nrm_root),
    .out_rem   (nrm_rem),
    .out_side  ({nrm_mag, nrm_neg})
  );

  // --------------------------------------------------------------------------
  // Dividend stage: mag * one + n / 2 gives round half up after division.
  // The norm is never zero, since the largest candidate sum is positive.
  // --------------------------------------------------------------------------
  logic                 dv_v;
  logic [3:0][DW-1:0]   dv_num;
  logic [NOW-1:0]       dv_den;
  logic [3:0]           dv_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v <= 1'b0;
    end else if (en) begin
      dv_v <= nrm_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        dv_num[i] <= (DW'(nrm_mag[i]) << FRAC_BITS) + DW'(nrm_root[0][NOW-1:1]);
      end
      dv_den <= nrm_root[0];
      dv_neg <= nrm_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Normalising division in four lanes.
  // --------------------------------------------------------------------------
  logic                 q_v;
  logic [3:0][QW-1:0]   q_mag;
  logic [3:0]           q_neg;

  r2q_div #(
    .LANES (4),
    .DW    (DW),
    .NW    (NOW),
    .QW    (QW),
    .SW    (4)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv_v),
    .in_num    (dv_num),
    .in_den    (dv_den),
    .in_side   (dv_neg),
    .out_valid (q_v),
    .out_quo   (q_mag),
    .out_side  (q_neg)
  );

  // --------------------------------------------------------------------------
  // Output register: clamp to one, apply the sign, saturate to the field.
  // --------------------------------------------------------------------------
  logic [3:0][DATA_W-1:0] res;

  always_comb begin
    int qc;
    int v;
    for (int i = 0; i < 4; i++) begin
      qc = int'(32'(q_mag[i]));
      if (qc > ONE_I) qc = ONE_I;
      v = q_neg[i] ? -qc : qc;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      res[i] = DATA_W'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
    end else if (en) begin
      quat.valid <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat.quat_w <= res[0];
      quat.quat_x <= res[1];
      quat.quat_y <= res[2];
      quat.quat_z <= res[3];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // Nothing leaves the pipeline in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !quat.valid)
    else $error("result valid straight after reset");

  // A held result stays held until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    quat.valid && !quat.ready |=> quat.valid && $stable(quat.quat_w))
    else $error("stalled result dropped or changed");

  // The largest component is kept positive, so not all four can be negative.
  a_one_positive: assert property (@(posedge clk) disable iff (rst)
    quat.valid |-> !(quat.quat_w[DATA_W-1] && quat.quat_x[DATA_W-1] &&
                     quat.quat_y[DATA_W-1] && quat.quat_z[DATA_W-1]))
    else $error("no non-negative component in result");

  // The input is taken exactly when the pipeline advances.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    mat.ready == (!quat.valid || quat.ready))
    else $error("input ready out of step with pipeline advance");

endmodule
